### design/bpc_pkg.sv
// ============================================================================
// bpc_pkg: shared types and constants of the ball position controller
// Fixed-point gains, offsets and limits, datapath widths and the
// command bundle between the controller and the datapath.
// ============================================================================
package bpc_pkg;

    // stream and config widths
    localparam int ADC_W      = 12;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int PULSE_W    = 16;
    localparam int ANG_W      = 14;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT_X = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT_Y = CFG_ADDR_W'(1);

    // shared multiplier: signed constant operand times signed variable operand
    localparam int MUL_A_W = 28;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // q2.20 positions and errors, with one guard width for sums
    localparam int POS_W   = 24;
    localparam int EXT_W   = POS_W + 1;
    localparam int ACC_W   = 40;
    localparam int ANG_SH  = 22;
    localparam int ANG_FULL_W = ACC_W - ANG_SH;
    localparam int RND_SH  = 16;

    // servo mapping: base scaled by 2^14, result taken from bit 30 up
    localparam int SERVO_W      = 46;
    localparam int SERVO_BASE_SH = 14;
    localparam int SERVO_SH     = 30;

    localparam logic signed [MUL_A_W-1:0] POS_GAIN_X    = MUL_A_W'(3088793);
    localparam logic signed [MUL_A_W-1:0] POS_GAIN_Y    = MUL_A_W'(2523761);
    localparam logic signed [EXT_W-1:0]   POS_OFS_X     = EXT_W'(-96075);
    localparam logic signed [EXT_W-1:0]   POS_OFS_Y     = EXT_W'(-80389);
    localparam logic signed [MUL_A_W-1:0] SP_SCALE_X    = MUL_A_W'(44640172);
    localparam logic signed [MUL_A_W-1:0] SP_SCALE_Y    = MUL_A_W'(33277544);
    localparam logic signed [EXT_W-1:0]   REJECT_LEVEL  = EXT_W'(91226);
    localparam logic signed [MUL_A_W-1:0] LAW_GAIN_NOW  = MUL_A_W'(508900);
    localparam logic signed [MUL_A_W-1:0] LAW_GAIN_OLD  = MUL_A_W'(426803);
    localparam logic signed [ANG_FULL_W-1:0] ANGLE_MAX  = ANG_FULL_W'(6554);
    localparam logic signed [ANG_FULL_W-1:0] ANGLE_MIN  = ANG_FULL_W'(-6554);
    localparam logic signed [SERVO_W-1:0] SERVO_BASE_X  = SERVO_W'(287152938);
    localparam logic signed [SERVO_W-1:0] SERVO_BASE_Y  = SERVO_W'(292751861);
    // y axis uses the negated slope
    localparam logic signed [MUL_A_W-1:0] SERVO_SLOPE_X = MUL_A_W'(121126974);
    localparam logic signed [MUL_A_W-1:0] SERVO_SLOPE_Y = MUL_A_W'(-122108012);

    // datapath step selected by the controller
    typedef enum logic [2:0] {
        OP_NONE,
        OP_POS,
        OP_SP,
        OP_ERR,
        OP_LAW,
        OP_ANG,
        OP_SERVO
    } bpc_op_t;

    typedef struct packed {
        logic    load_in;
        bpc_op_t op;
        logic    load_out;
    } bpc_cmd_t;

endpackage

### design/two_axis_ball_position_controller_core.sv
// ============================================================================
// two_axis_ball_position_controller_core: lead compensator for a ball plate
// Turns touch-panel samples into saturated servo angles and timer compares.
// ============================================================================
// Each accepted sample (axis on s_tuser, 12-bit reading on s_tdata) yields
// exactly one result on the master stream. From acceptance to a finished
// result a sample passes the accept state, then six sequencer steps
// (five through the single shared 28x25 signed multiplier and one for angle
// rounding and saturation) and the servo sum in the done state; the sequencer
// works on one sample at a time and accepts no new sample before it has
// passed its result on. The result sits in an output register,
// so the next sample is taken while a previous result is still waiting; a
// finished result waits in the sequencer only if that register is still full.
// Per axis it keeps the last position and the last error, both cleared by reset.
// Setpoints are to be written through the config port while no sample is in
// flight; the block does not enforce it. Index 0 is x, index 1 is y, others ignored.
// ============================================================================
module two_axis_ball_position_controller_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // sample stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bpc_pkg::IN_DATA_W-1:0]       s_tdata,   // adc_sample[11:0], zero pad
    input  logic                                s_tuser,   // axis
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bpc_pkg::OUT_DATA_W-1:0]      m_tdata,   // pulse_ticks[15:0],
                                                           // angle_command[29:16],
                                                           // limited[30], rejected[31]
    output logic                                m_tuser,   // axis_out
    // config write port
    input  logic                                cfg_we,
    input  logic [bpc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import bpc_pkg::*;

    // setpoint registers, raw signed steps
    logic signed [CFG_DATA_W-1:0] setpoint_x_reg;
    logic signed [CFG_DATA_W-1:0] setpoint_y_reg;

    bpc_cmd_t                     cmd;
    logic [PULSE_W-1:0]           pulse_ticks;
    logic signed [ANG_W-1:0]      angle_command;
    logic                         limited;
    logic                         rejected;

    // register decode, unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_x_reg <= '0;
            setpoint_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SETPOINT_X: setpoint_x_reg <= $signed(cfg_wdata);
                REG_SETPOINT_Y: setpoint_y_reg <= $signed(cfg_wdata);
                default:
                begin
                    setpoint_x_reg <= setpoint_x_reg;
                    setpoint_y_reg <= setpoint_y_reg;
                end
            endcase
        end
    end

    // sequencer: one sample at a time, owns both handshakes
    bpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    // shared multiplier, history and output register
    bpc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .axis          (s_tuser),
        .adc_sample    (s_tdata[ADC_W-1:0]),
        .setpoint_x    (setpoint_x_reg),
        .setpoint_y    (setpoint_y_reg),
        .axis_out      (m_tuser),
        .pulse_ticks   (pulse_ticks),
        .angle_command (angle_command),
        .limited       (limited),
        .rejected      (rejected)
    );

    // result packing, lowest field first
    assign m_tdata = {rejected, limited, angle_command, pulse_ticks};

endmodule

### design/bpc_ctrl.sv
// ============================================================================
// bpc_ctrl: sequencer of the ball position controller
// Walks one sample through the datapath steps and owns the output valid.
// ============================================================================
module bpc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output bpc_pkg::bpc_cmd_t cmd
);
    import bpc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_SP,
        S_ERR,
        S_LAW,
        S_ANG,
        S_SERVO,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load_in  = 1'b0;
        cmd.op       = OP_NONE;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_POS;
                end
            end
            S_POS:
            begin
                cmd.op     = OP_POS;
                state_next = S_SP;
            end
            S_SP:
            begin
                cmd.op     = OP_SP;
                state_next = S_ERR;
            end
            S_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = S_LAW;
            end
            S_LAW:
            begin
                cmd.op     = OP_LAW;
                state_next = S_ANG;
            end
            S_ANG:
            begin
                cmd.op     = OP_ANG;
                state_next = S_SERVO;
            end
            S_SERVO:
            begin
                cmd.op     = OP_SERVO;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // an accepted sample always starts the position step
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_POS))
        else $error("accepted sample did not start the position step");

    // a finished result waits while the output register is still held
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("result left the sequencer while the output was stalled");

    // output valid only rises when a finished result is published
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("output valid rose without a finished result");

endmodule

### design/bpc_datapath.sv
// ============================================================================
// bpc_datapath: arithmetic of the ball position controller
// One shared signed multiplier, per-axis history and the output register.
// ============================================================================
module bpc_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  bpc_pkg::bpc_cmd_t                       cmd,
    input  logic                                    axis,
    input  logic [bpc_pkg::ADC_W-1:0]               adc_sample,
    input  logic signed [bpc_pkg::CFG_DATA_W-1:0]   setpoint_x,
    input  logic signed [bpc_pkg::CFG_DATA_W-1:0]   setpoint_y,
    output logic                                    axis_out,
    output logic [bpc_pkg::PULSE_W-1:0]             pulse_ticks,
    output logic signed [bpc_pkg::ANG_W-1:0]        angle_command,
    output logic                                    limited,
    output logic                                    rejected
);
    import bpc_pkg::*;

    // sample and step registers
    logic                        axis_reg;
    logic [ADC_W-1:0]            adc_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [POS_W-1:0]     pos_reg;
    logic                        rej_reg;
    logic signed [POS_W-1:0]     err_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ANG_W-1:0]     ang_reg;
    logic                        lim_reg;

    // per-axis history
    logic signed [POS_W-1:0]     prior_pos_reg [2];
    logic signed [POS_W-1:0]     prior_err_reg [2];

    // output register
    logic                        axis_out_reg;
    logic [PULSE_W-1:0]          pulse_reg;
    logic signed [ANG_W-1:0]     ang_out_reg;
    logic                        lim_out_reg;
    logic                        rej_out_reg;

    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]    prod_next;
    logic signed [PROD_W-1:0]    prod_rnd;
    logic signed [EXT_W-1:0]     scaled;
    logic signed [POS_W-1:0]     prior_pos;
    logic signed [POS_W-1:0]     prior_err;
    logic signed [EXT_W-1:0]     pos_raw;
    logic                        rej_next;
    logic signed [POS_W-1:0]     pos_next;
    logic signed [EXT_W-1:0]     pos_sum;
    logic signed [POS_W-1:0]     avg;
    logic signed [EXT_W-1:0]     err_full;
    logic signed [POS_W-1:0]     err_next;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [ACC_W-1:0]     acc_rnd;
    logic signed [ANG_FULL_W-1:0] ang_full;
    logic signed [ANG_W-1:0]     ang_next;
    logic                        lim_next;
    logic signed [SERVO_W-1:0]   servo_base;
    logic signed [SERVO_W-1:0]   pulse_full;

    assign prior_pos = prior_pos_reg[axis_reg];
    assign prior_err = prior_err_reg[axis_reg];

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op) inside
            OP_POS:
            begin
                mul_a = axis_reg ? POS_GAIN_Y : POS_GAIN_X;
                mul_b = $signed(MUL_B_W'(adc_reg));
            end
            OP_SP:
            begin
                mul_a = axis_reg ? SP_SCALE_Y : SP_SCALE_X;
                mul_b = axis_reg ? MUL_B_W'(setpoint_y) : MUL_B_W'(setpoint_x);
            end
            OP_ERR:
            begin
                mul_a = LAW_GAIN_OLD;
                mul_b = MUL_B_W'(prior_err);
            end
            OP_LAW:
            begin
                mul_a = LAW_GAIN_NOW;
                mul_b = MUL_B_W'(err_reg);
            end
            OP_SERVO:
            begin
                mul_a = axis_reg ? SERVO_SLOPE_Y : SERVO_SLOPE_X;
                mul_b = MUL_B_W'(ang_reg);
            end
            OP_NONE, OP_ANG:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // round half up of the last product, q.36 to q2.20
    always_comb
    begin
        prod_rnd = prod_reg + PROD_W'(1 << (RND_SH - 1));
        scaled   = $signed(prod_rnd[RND_SH +: EXT_W]);

        // position and noise rejection
        pos_raw  = scaled + (axis_reg ? POS_OFS_Y : POS_OFS_X);
        rej_next = (pos_raw >= REJECT_LEVEL);
        pos_next = rej_next ? prior_pos : pos_raw[POS_W-1:0];

        // floor average and error against the scaled setpoint
        pos_sum  = EXT_W'(pos_reg) + EXT_W'(prior_pos);
        avg      = pos_sum[EXT_W-1:1];
        err_full = scaled - EXT_W'(avg);
        err_next = err_full[POS_W-1:0];

        // law, rounding to q2.14 and saturation
        acc_next = ACC_W'(prod_reg) - acc_reg;
        acc_rnd  = acc_next + ACC_W'(1 << (ANG_SH - 1));
        ang_full = $signed(acc_rnd[ACC_W-1:ANG_SH]);
        lim_next = 1'b0;
        if (ang_full > ANGLE_MAX)
        begin
            ang_next = ANGLE_MAX[ANG_W-1:0];
            lim_next = 1'b1;
        end
        else if (ang_full < ANGLE_MIN)
        begin
            ang_next = ANGLE_MIN[ANG_W-1:0];
            lim_next = 1'b1;
        end
        else
        begin
            ang_next = ang_full[ANG_W-1:0];
        end

        // servo compare value, floor by 2^30
        servo_base = (axis_reg ? SERVO_BASE_Y : SERVO_BASE_X) <<< SERVO_BASE_SH;
        pulse_full = servo_base + SERVO_W'(prod_reg);
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            axis_reg <= axis;
            adc_reg  <= adc_sample;
        end
        if (cmd.op != OP_NONE && cmd.op != OP_ANG)
            prod_reg <= prod_next;
        if (cmd.op == OP_SP)
        begin
            pos_reg <= pos_next;
            rej_reg <= rej_next;
        end
        if (cmd.op == OP_ERR)
            err_reg <= err_next;
        if (cmd.op == OP_LAW)
            acc_reg <= ACC_W'(prod_reg);
        if (cmd.op == OP_ANG)
        begin
            ang_reg <= ang_next;
            lim_reg <= lim_next;
        end
        if (cmd.load_out)
        begin
            axis_out_reg <= axis_reg;
            pulse_reg    <= pulse_full[SERVO_SH +: PULSE_W];
            ang_out_reg  <= ang_reg;
            lim_out_reg  <= lim_reg;
            rej_out_reg  <= rej_reg;
        end
    end

    // history, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_pos_reg[0] <= '0;
            prior_pos_reg[1] <= '0;
            prior_err_reg[0] <= '0;
            prior_err_reg[1] <= '0;
        end
        else
        begin
            if (cmd.op == OP_ERR)
                prior_pos_reg[axis_reg] <= pos_reg;
            if (cmd.op == OP_LAW)
                prior_err_reg[axis_reg] <= err_reg;
        end
    end

    assign axis_out      = axis_out_reg;
    assign pulse_ticks   = pulse_reg;
    assign angle_command = ang_out_reg;
    assign limited       = lim_out_reg;
    assign rejected      = rej_out_reg;

endmodule

### verif/tb_two_axis_ball_position_controller_core.sv
// ============================================================================
// tb_two_axis_ball_position_controller_core: self-checking bench for the core
// Streams panel samples through the block under random source gaps and sink
// stalls. Each accepted sample runs through an in-bench fixed-point copy of
// the per-axis position filter, lead law and servo mapping, and the result is
// compared field by field with the next servo command from the block.
// ============================================================================
module tb_two_axis_ball_position_controller_core;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 12;

    // spare register indexes, writes there must be ignored
    localparam logic [bpc_pkg::CFG_ADDR_W-1:0] REG_SPARE_A = bpc_pkg::CFG_ADDR_W'(2);
    localparam logic [bpc_pkg::CFG_ADDR_W-1:0] REG_SPARE_B = bpc_pkg::CFG_ADDR_W'(3);

    // calibration and law constants, q2.20 metres / q2.14 radians
    localparam longint X_POS_GAIN = 3088793;
    localparam longint X_POS_OFFS = -96075;
    localparam longint Y_POS_GAIN = 2523761;
    localparam longint Y_POS_OFFS = -80389;
    localparam longint X_SP_SCALE = 44640172;
    localparam longint Y_SP_SCALE = 33277544;
    localparam longint NOISE_LEVEL = 91226;
    localparam longint K_NOW = 508900;
    localparam longint K_OLD = 426803;
    localparam longint ANGLE_SAT = 6554;
    localparam longint X_SERVO_BASE = 287152938;
    localparam longint X_SERVO_SLOPE = 121126974;
    localparam longint Y_SERVO_BASE = 292751861;
    localparam longint Y_SERVO_SLOPE = 122108012;

    typedef struct packed {
        logic                    axis;
        logic [15:0]             ticks;
        logic signed [13:0]      angle;
        logic                    limited;
        logic                    rejected;
    } servo_cmd_t;

    typedef struct packed {
        logic                             axis;
        logic [bpc_pkg::IN_DATA_W-1:0]    word;
    } panel_sample_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [bpc_pkg::IN_DATA_W-1:0] s_tdata = '0;   // adc_sample[11:0], zero pad
    logic s_tuser = 1'b0;                          // axis
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [bpc_pkg::OUT_DATA_W-1:0] m_tdata;       // pulse_ticks[15:0], angle_command[29:16],
                                                   // limited[30], rejected[31]
    logic m_tuser;                                 // axis_out
    logic cfg_we = 1'b0;
    logic [bpc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [bpc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    two_axis_ball_position_controller_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // controller state mirrored in the bench
    logic signed [7:0] sp_x = '0;
    logic signed [7:0] sp_y = '0;
    longint last_pos [2] = '{0, 0};
    longint last_err [2] = '{0, 0};

    panel_sample_t sample_backlog [$];
    servo_cmd_t    due_commands [$];

    int  fail_count = 0;
    int  cmds_seen = 0;
    int  cycle_count = 0;
    bit  sample_taken = 1'b0;
    bit  cmd_taken = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  steady_send = 1'b0;
    bit  steady_recv = 1'b0;
    panel_sample_t next_sample;
    servo_cmd_t want;
    servo_cmd_t got;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // position filter, lead law with saturation and servo mapping for one sample
    function automatic servo_cmd_t servo_law(input logic ax, input logic [11:0] adc);
        servo_cmd_t c;
        longint pos;
        longint sp;
        longint mean;
        longint err;
        longint acc;
        longint ang;
        longint pulse;
        c.axis = ax;
        c.limited = 1'b0;
        c.rejected = 1'b0;
        if (ax == 1'b0)
        begin
            pos = ((longint'(adc) * X_POS_GAIN + 64'sd32768) >>> 16) + X_POS_OFFS;
            sp = (longint'(sp_x) * X_SP_SCALE + 64'sd32768) >>> 16;
        end
        else
        begin
            pos = ((longint'(adc) * Y_POS_GAIN + 64'sd32768) >>> 16) + Y_POS_OFFS;
            sp = (longint'(sp_y) * Y_SP_SCALE + 64'sd32768) >>> 16;
        end
        // reading beyond the panel edge: hold the last position
        if (pos >= NOISE_LEVEL)
        begin
            pos = last_pos[ax];
            c.rejected = 1'b1;
        end
        mean = (pos + last_pos[ax]) >>> 1;
        last_pos[ax] = pos;
        err = sp - mean;
        acc = K_NOW * err - K_OLD * last_err[ax];
        last_err[ax] = err;
        ang = (acc + 64'sd2097152) >>> 22;
        // exactly at the limit is not flagged
        if (ang > ANGLE_SAT)
        begin
            ang = ANGLE_SAT;
            c.limited = 1'b1;
        end
        else if (ang < -ANGLE_SAT)
        begin
            ang = -ANGLE_SAT;
            c.limited = 1'b1;
        end
        if (ax == 1'b0)
            pulse = (X_SERVO_BASE * 16384 + X_SERVO_SLOPE * ang) >>> 30;
        else
            pulse = (Y_SERVO_BASE * 16384 - Y_SERVO_SLOPE * ang) >>> 30;
        c.ticks = pulse[15:0];
        c.angle = ang[13:0];
        return c;
    endfunction

    function automatic int draw_idle(input bit steady);
        return steady ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic panel_sample_t random_sample();
        panel_sample_t s;
        logic [11:0] reading;
        logic [3:0] pad;
        case ($urandom_range(0, 9))
            0: reading = 12'($urandom_range(3900, 4095));     // around the noise threshold
            1: reading = $urandom_range(0, 1) ? 12'd0 : 12'd4095;
            2, 3, 4: reading = 12'($urandom());
            default: reading = 12'($urandom_range(1500, 2600)); // near center, law unsaturated
        endcase
        pad = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'h0;
        s.axis = 1'($urandom_range(0, 1));
        s.word = {pad, reading};
        return s;
    endfunction

    task automatic queue_sample(input logic ax, input logic [bpc_pkg::IN_DATA_W-1:0] word);
        panel_sample_t s;
        s.axis = ax;
        s.word = word;
        sample_backlog.push_back(s);
    endtask

    task automatic queue_random(input int n);
        repeat (n) sample_backlog.push_back(random_sample());
    endtask

    // sender pause: wait until every queued sample has its command back
    task automatic drain();
        while (sample_backlog.size() != 0 || s_tvalid || due_commands.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic [bpc_pkg::CFG_ADDR_W-1:0] idx,
                                input logic [bpc_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            bpc_pkg::REG_SETPOINT_X: sp_x = val;
            bpc_pkg::REG_SETPOINT_Y: sp_y = val;
            default: ;
        endcase
    endtask

    task automatic set_targets(input logic [7:0] x_raw, input logic [7:0] y_raw);
        set_register(bpc_pkg::REG_SETPOINT_X, x_raw);
        set_register(bpc_pkg::REG_SETPOINT_Y, y_raw);
    endtask

    // capture both handshakes at the rising edge
    always @(posedge clk)
    begin
        sample_taken = 1'b0;
        cmd_taken = 1'b0;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                due_commands.push_back(servo_law(s_tuser, s_tdata[bpc_pkg::ADC_W-1:0]));
                sample_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                cmd_taken = 1'b1;
                cmds_seen++;
                got.axis = m_tuser;
                got.ticks = m_tdata[15:0];
                got.angle = m_tdata[29:16];
                got.limited = m_tdata[30];
                got.rejected = m_tdata[31];
                if (due_commands.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected servo command: axis %0d tdata %h", m_tuser, m_tdata);
                end
                else
                begin
                    want = due_commands.pop_front();
                    if (got.axis !== want.axis || got.ticks !== want.ticks
                        || got.angle !== want.angle || got.limited !== want.limited
                        || got.rejected !== want.rejected)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $write("mismatch (exp/got): axis %0d/%0d ticks %0d/%0d",
                                   want.axis, got.axis, want.ticks, got.ticks);
                            $display(" angle %0d/%0d limited %0d/%0d rejected %0d/%0d",
                                     want.angle, got.angle, want.limited, got.limited,
                                     want.rejected, got.rejected);
                        end
                    end
                end
            end
        end
    end

    // sample source: random gap after each transfer, occasional gap-free runs
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || sample_taken)
        begin
            if (sample_taken)
            begin
                if ($urandom_range(0, 40) == 0)
                    steady_send = !steady_send;
                gap_left = draw_idle(steady_send);
            end
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (sample_backlog.size() != 0)
            begin
                next_sample = sample_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= next_sample.word;
                s_tuser <= next_sample.axis;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // command sink: random stall per transfer, plus a few long holds that
    // back the block up while samples keep coming
    always @(negedge clk)
    begin
        if (cmd_taken)
        begin
            if (cmds_seen == 40 || cmds_seen == 200 || cmds_seen == 380)
                hold_left = $urandom_range(120, 250);
            if ($urandom_range(0, 40) == 0)
                steady_recv = !steady_recv;
            stall_left = draw_idle(steady_recv);
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed, zero targets: panel extremes, just below and just over the
        // noise threshold on x, centered readings, pad bits set
        queue_sample(1'b0, 16'd0);
        queue_sample(1'b0, 16'd4095);
        queue_sample(1'b0, 16'd3974);
        queue_sample(1'b0, 16'd3975);
        queue_sample(1'b0, 16'd2038);
        queue_sample(1'b1, 16'd0);
        queue_sample(1'b1, 16'd4095);
        queue_sample(1'b1, 16'd2087);
        queue_sample(1'b0, 16'hF7F6);
        queue_sample(1'b1, 16'hA827);
        drain();

        // target extremes, both directions, drive the law into saturation
        set_targets(8'sd127, -8'sd128);
        queue_sample(1'b0, 16'd0);
        queue_sample(1'b0, 16'd2038);
        queue_sample(1'b1, 16'd4095);
        queue_sample(1'b1, 16'd2087);
        drain();
        set_targets(-8'sd128, 8'sd127);
        queue_sample(1'b0, 16'd4095);
        queue_sample(1'b0, 16'd0);
        queue_sample(1'b1, 16'd0);
        queue_sample(1'b1, 16'd4095);
        drain();

        // writes to indexes past the register list change nothing
        set_register(REG_SPARE_A, 8'($urandom()));
        set_register(REG_SPARE_B, 8'($urandom()));
        queue_sample(1'b0, 16'd2038);
        queue_sample(1'b1, 16'd2087);
        drain();

        // random phases under several target settings
        set_targets(8'sd0, 8'sd0);
        queue_random(75);
        drain();
        set_targets(8'sd127, -8'sd128);
        queue_random(75);
        drain();
        set_targets(8'($urandom()), 8'($urandom()));
        queue_random(75);
        drain();
        set_targets(-8'sd128, 8'sd127);
        queue_random(75);
        drain();
        set_register(REG_SPARE_A, 8'($urandom()));
        set_targets(8'($urandom()), 8'($urandom()));
        queue_random(75);
        drain();
        set_targets(-8'sd1, 8'sd1);
        queue_random(75);
        drain();

        if (due_commands.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
